>>> hw/rtl/pts_pkg.sv
// Package for the priority task scheduler.
// Widths, command and run-state codes, priority limits and the
// controller/datapath command and status types. No dependencies.
`default_nettype none

package pts_pkg;

    // Table geometry
    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = 4;
    localparam int EMPTY_W    = SLOT_W + 1;

    // Field widths
    localparam int CMD_W  = 3;
    localparam int CHAN_W = 32;
    localparam int PRIO_W = 9;
    localparam int NICE_W = 7;
    localparam int CPU_W  = 8;
    localparam int BASE_W = 8;
    localparam int RS_W   = 2;
    localparam int SUM_W  = PRIO_W + 1;

    // Command codes
    localparam logic [CMD_W-1:0] OP_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] OP_SLEEP = 3'd1;
    localparam logic [CMD_W-1:0] OP_WAKE  = 3'd2;
    localparam logic [CMD_W-1:0] OP_TICK  = 3'd3;
    localparam logic [CMD_W-1:0] OP_SCHED = 3'd4;

    // Run states
    localparam logic [RS_W-1:0] RS_RUNNING         = 2'd0;
    localparam logic [RS_W-1:0] RS_INTERRUPTIBLE   = 2'd1;
    localparam logic [RS_W-1:0] RS_UNINTERRUPTIBLE = 2'd2;

    // Priority limits
    localparam logic signed [PRIO_W-1:0] PRIO_PICK_LIMIT = 9'sd127;
    localparam logic signed [SUM_W-1:0]  PRIO_CLAMP_HI   = 10'sd128;
    localparam logic signed [SUM_W-1:0]  PRIO_CLAMP_LO   = -10'sd126;
    localparam logic signed [BASE_W-1:0] BASE_RESET      = 8'sd100;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // input transfer: latch item, apply write/sleep
        logic walk;     // process slot at walk index
        logic load;     // commit current slot, load result register
    } t_dp_ctrl;

    // Datapath to controller status
    typedef struct packed {
        logic walk_last;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hw/rtl/pts_cmd_if.sv
// Command channel interface for the priority task scheduler.
// Depends on pts_pkg for field widths.
`default_nettype none

interface pts_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [pts_pkg::CMD_W-1:0]            command;
    logic [pts_pkg::SLOT_W-1:0]           slot_index;
    logic                                 slot_present;
    logic [pts_pkg::CHAN_W-1:0]           wait_channel;
    logic signed [pts_pkg::PRIO_W-1:0]    priority_in;
    logic signed [pts_pkg::NICE_W-1:0]    nice_in;
    logic [pts_pkg::CPU_W-1:0]            cpu_in;

    modport source (output valid, command, slot_index, slot_present, wait_channel,
                    priority_in, nice_in, cpu_in, input ready);
    modport sink   (input valid, command, slot_index, slot_present, wait_channel,
                    priority_in, nice_in, cpu_in, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pts_res_if.sv
// Result channel interface for the priority task scheduler.
// Depends on pts_pkg for field widths.
`default_nettype none

interface pts_res_if;
    logic                          valid;
    logic                          ready;
    logic [pts_pkg::SLOT_W-1:0]    running_slot;
    logic                          switched;
    logic [pts_pkg::EMPTY_W-1:0]   empty_slot;
    logic                          panic_flag;

    modport source (output valid, running_slot, switched, empty_slot, panic_flag,
                    input ready);
    modport sink   (input valid, running_slot, switched, empty_slot, panic_flag,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pts_cfg_if.sv
// Configuration write channel for the priority task scheduler.
// Depends on pts_pkg for the register width.
`default_nettype none

interface pts_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pts_pkg::BASE_W-1:0]    user_base_priority;

    modport source (output valid, user_base_priority, input ready);
    modport sink   (input valid, user_base_priority, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pts_ctrl.sv
// Controller FSM of the priority task scheduler: accept, slot walk, result load.
// Depends on pts_pkg for the command/status structs.
`default_nettype none

module pts_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output pts_pkg::t_dp_ctrl      o_ctrl,
    input  wire pts_pkg::t_dp_sts  i_sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept, load;

    // handshake decode
    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign load   = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_ctrl.accept = accept;
    assign o_ctrl.walk   = (r_state == S_WALK);
    assign o_ctrl.load   = load;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_last) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result register valid: cleared on transfer, set on load
    assign n_out_valid = (r_out_valid && !i_out_ready) || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_WALK))
        else $error("accepted command did not start the slot walk");

    a_walk_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_sts.walk_last) |=> (r_state == S_LOAD))
        else $error("slot walk end did not reach result load");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_valid)
        else $error("result load did not raise output valid");

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_out_valid && !i_out_ready) |=> (r_state == S_LOAD))
        else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/pts_dp.sv
// Datapath of the priority task scheduler: task table, slot walk for
// schedule/wakeup/tick/free-slot search, base priority register, result register.
// Depends on pts_pkg.
`default_nettype none

module pts_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pts_pkg::t_dp_ctrl                   i_ctrl,
    output pts_pkg::t_dp_sts                         o_sts,
    // configuration write
    input  wire logic                                i_cfg_we,
    input  wire logic signed [pts_pkg::BASE_W-1:0]   i_cfg_base,
    // command payload
    input  wire logic [pts_pkg::CMD_W-1:0]           i_command,
    input  wire logic [pts_pkg::SLOT_W-1:0]          i_slot_index,
    input  wire logic                                i_slot_present,
    input  wire logic [pts_pkg::CHAN_W-1:0]          i_wait_channel,
    input  wire logic signed [pts_pkg::PRIO_W-1:0]   i_priority_in,
    input  wire logic signed [pts_pkg::NICE_W-1:0]   i_nice_in,
    input  wire logic [pts_pkg::CPU_W-1:0]           i_cpu_in,
    // result payload
    output logic [pts_pkg::SLOT_W-1:0]               o_running_slot,
    output logic                                     o_switched,
    output logic [pts_pkg::EMPTY_W-1:0]              o_empty_slot,
    output logic                                     o_panic_flag
);

    localparam int N = pts_pkg::TASK_SLOTS;

    // task table
    logic                                r_present [N];
    logic [pts_pkg::RS_W-1:0]            r_run     [N];
    logic [pts_pkg::CHAN_W-1:0]          r_chan    [N];
    logic signed [pts_pkg::PRIO_W-1:0]   r_prio    [N];
    logic [pts_pkg::CPU_W-1:0]           r_cpu     [N];
    logic signed [pts_pkg::NICE_W-1:0]   r_nice    [N];

    logic [pts_pkg::SLOT_W-1:0]          r_cur;
    logic signed [pts_pkg::BASE_W-1:0]   r_base;

    // latched command
    logic [pts_pkg::CMD_W-1:0]           r_op;
    logic [pts_pkg::CHAN_W-1:0]          r_chan_in;
    logic                                r_sched;
    logic                                r_panic;

    // walk state
    logic [pts_pkg::SLOT_W-1:0]          r_wi;
    logic signed [pts_pkg::PRIO_W-1:0]   r_best;
    logic                                r_found;
    logic [pts_pkg::SLOT_W-1:0]          r_pick;
    logic [pts_pkg::EMPTY_W-1:0]         r_empty;
    logic                                r_efound;

    // result register
    logic [pts_pkg::SLOT_W-1:0]          r_out_slot;
    logic                                r_out_sw;
    logic [pts_pkg::EMPTY_W-1:0]         r_out_empty;
    logic                                r_out_panic;

    // element under the walk
    logic                                e_present;
    logic [pts_pkg::RS_W-1:0]            e_run;
    logic signed [pts_pkg::PRIO_W-1:0]   e_prio;
    logic [pts_pkg::CPU_W-1:0]           e_cpu_half;
    logic signed [pts_pkg::SUM_W-1:0]    e_sum;
    logic signed [pts_pkg::PRIO_W-1:0]   e_new_prio;
    logic                                e_recalc;
    logic                                e_cand;
    logic                                e_wake;
    logic                                sleep_ok;
    logic [pts_pkg::SLOT_W-1:0]          next_cur;

    assign e_present  = r_present[r_wi];
    assign e_run      = r_run[r_wi];
    assign e_prio     = r_prio[r_wi];
    assign e_cpu_half = r_cpu[r_wi] >> 1;

    // tick recompute: 2*nice + base + cpu/8, then clamp
    assign e_sum = pts_pkg::SUM_W'(r_nice[r_wi]) + pts_pkg::SUM_W'(r_nice[r_wi])
                 + pts_pkg::SUM_W'(r_base)
                 + pts_pkg::SUM_W'({1'b0, e_cpu_half[pts_pkg::CPU_W-1:2]});

    always_comb begin
        if (e_sum > pts_pkg::PRIO_CLAMP_HI) begin
            e_new_prio = pts_pkg::PRIO_W'(pts_pkg::PRIO_CLAMP_HI);
        end else if (e_sum <= pts_pkg::PRIO_CLAMP_LO) begin
            e_new_prio = pts_pkg::PRIO_W'(pts_pkg::PRIO_CLAMP_LO);
        end else begin
            e_new_prio = e_sum[pts_pkg::PRIO_W-1:0];
        end
    end

    assign e_recalc = e_prio > pts_pkg::PRIO_W'(r_base);

    // schedule candidate: present, not current, running or slot zero, priority at most the best so far
    assign e_cand = e_present && (r_wi != r_cur)
                 && ((e_run == pts_pkg::RS_RUNNING) || (r_wi == '0))
                 && (e_prio <= r_best);

    assign e_wake = e_present && (r_chan[r_wi] == r_chan_in);

    assign sleep_ok = (r_cur != '0);

    assign next_cur = r_sched ? (r_found ? r_pick : '0) : r_cur;

    assign o_sts.walk_last = (r_wi == pts_pkg::SLOT_W'(N - 1));

    // control state: presence, run state, current slot, base, walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_present[k] <= 1'b0;
                r_run[k]     <= pts_pkg::RS_RUNNING;
            end
            r_cur    <= '0;
            r_base   <= pts_pkg::BASE_RESET;
            r_wi     <= '0;
            r_found  <= 1'b0;
            r_efound <= 1'b0;
            r_sched  <= 1'b0;
            r_panic  <= 1'b0;
        end else begin
            if (i_cfg_we) r_base <= i_cfg_base;

            if (i_ctrl.accept) begin
                r_wi     <= '0;
                r_found  <= 1'b0;
                r_efound <= 1'b0;
                r_sched  <= ((i_command == pts_pkg::OP_SLEEP) && sleep_ok)
                         || (i_command == pts_pkg::OP_SCHED);
                r_panic  <= (i_command == pts_pkg::OP_SLEEP) && !sleep_ok;
                case (i_command)
                    pts_pkg::OP_WRITE: begin
                        r_present[i_slot_index] <= i_slot_present;
                        r_run[i_slot_index]     <= pts_pkg::RS_RUNNING;
                    end
                    pts_pkg::OP_SLEEP: begin
                        if (sleep_ok) begin
                            r_run[r_cur] <= i_priority_in[pts_pkg::PRIO_W-1]
                                          ? pts_pkg::RS_UNINTERRUPTIBLE
                                          : pts_pkg::RS_INTERRUPTIBLE;
                        end
                    end
                    default: ;
                endcase
            end

            if (i_ctrl.walk) begin
                r_wi <= r_wi + 1'b1;
                if (r_sched && e_cand) r_found <= 1'b1;
                if (!e_present) r_efound <= 1'b1;
                if (r_op == pts_pkg::OP_WAKE && e_wake) r_run[r_wi] <= pts_pkg::RS_RUNNING;
            end

            if (i_ctrl.load) r_cur <= next_cur;
        end
    end

    // payload state: table contents, walk results, result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_op      <= i_command;
            r_chan_in <= i_wait_channel;
            r_best    <= pts_pkg::PRIO_PICK_LIMIT;
            r_pick    <= '0;
            r_empty   <= pts_pkg::EMPTY_W'(N);
            case (i_command)
                pts_pkg::OP_WRITE: begin
                    r_chan[i_slot_index] <= '0;
                    r_prio[i_slot_index] <= i_priority_in;
                    r_nice[i_slot_index] <= i_nice_in;
                    r_cpu[i_slot_index]  <= i_cpu_in;
                end
                pts_pkg::OP_SLEEP: begin
                    if (sleep_ok) begin
                        r_chan[r_cur] <= i_wait_channel;
                        r_prio[r_cur] <= i_priority_in;
                    end
                end
                default: ;
            endcase
        end

        if (i_ctrl.walk) begin
            // lowest free slot
            if (!r_efound && !e_present) r_empty <= {1'b0, r_wi};
            // schedule: later slot wins ties
            if (r_sched && e_cand) begin
                r_best <= e_prio;
                r_pick <= r_wi;
            end
            case (r_op)
                pts_pkg::OP_WAKE: begin
                    if (e_wake) r_chan[r_wi] <= '0;
                end
                pts_pkg::OP_TICK: begin
                    if (e_present) begin
                        r_cpu[r_wi] <= e_cpu_half;
                        if (e_recalc) r_prio[r_wi] <= e_new_prio;
                    end
                end
                default: ;
            endcase
        end

        if (i_ctrl.load) begin
            r_out_slot  <= next_cur;
            r_out_sw    <= (next_cur != r_cur);
            r_out_empty <= r_empty;
            r_out_panic <= r_panic;
        end
    end

    assign o_running_slot = r_out_slot;
    assign o_switched     = r_out_sw;
    assign o_empty_slot   = r_out_empty;
    assign o_panic_flag   = r_out_panic;

endmodule

`default_nettype wire

>>> hw/rtl/priority_task_scheduler.sv
// Priority task scheduler, top level. The single walk over the table keeps new
// commands out until it ends: the transfer cycle applies slot writes and sleeps,
// then one table slot is visited per cycle for all 16 slots, then the load step
// commits and loads the result register, holding while an earlier result is
// untaken; result valid and ready rise with the load. Active-low sync reset
// empties the table, marks all slots running, sets slot 0 current and base 100.
// Depends on pts_pkg, pts_cmd_if, pts_res_if, pts_cfg_if, pts_ctrl, pts_dp.
`default_nettype none

module priority_task_scheduler (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pts_cmd_if.sink    i_cmd,
    pts_res_if.source  o_res,
    pts_cfg_if.sink    i_cfg
);

    pts_pkg::t_dp_ctrl ctrl;
    pts_pkg::t_dp_sts  sts;

    // base priority register always takes writes
    assign i_cfg.ready = 1'b1;

    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_ctrl      (ctrl),
        .i_sts       (sts)
    );

    pts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_base     (i_cfg.user_base_priority),
        .i_command      (i_cmd.command),
        .i_slot_index   (i_cmd.slot_index),
        .i_slot_present (i_cmd.slot_present),
        .i_wait_channel (i_cmd.wait_channel),
        .i_priority_in  (i_cmd.priority_in),
        .i_nice_in      (i_cmd.nice_in),
        .i_cpu_in       (i_cmd.cpu_in),
        .o_running_slot (o_res.running_slot),
        .o_switched     (o_res.switched),
        .o_empty_slot   (o_res.empty_slot),
        .o_panic_flag   (o_res.panic_flag)
    );

endmodule

`default_nettype wire
